/* rtl/core/ede_pkg.sv */
`timescale 1ns / 1ps

package ede_pkg;

    // Fixed field widths
    localparam int SYM_W       = 8;
    localparam int REQ_W       = 2;
    localparam int DIST_W      = 7;
    localparam int MAX_LEN_DEF = 64;

    // Request codes carried on the input tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_FIRST  = 2'd0,
        REQ_SECOND = 2'd1,
        REQ_FINISH = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COL,
        ST_FIN
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_pat;   // store a first-string symbol
        logic set_drop;   // mark a dropped symbol
        logic sec_inc;    // second length grows, alone or closing a column walk
        logic col_start;  // latch symbol, prime the column walk
        logic col_step;   // update one cell of the column
        logic fin_read;   // fetch the final cell
        logic fin_emit;   // load the output register, clear the pair
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic first_zero;
        logic first_full;
        logic sec_zero;
        logic sec_full;
        logic last_cell;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/core/ede_ctrl.sv */
`timescale 1ns / 1ps

module ede_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ede_pkg::REQ_W-1:0] in_req,
    input  ede_pkg::dp_status_t    status,
    output ede_pkg::ctrl_cmd_t     cmd
);
    import ede_pkg::*;

    state_t state_reg;
    state_t state_next;
    req_t   req;

    assign req = req_t'(in_req);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (req)
                        REQ_FIRST:
                        begin
                            if (status.sec_zero && !status.first_full)
                                cmd.load_pat = 1'b1;
                            else
                                cmd.set_drop = 1'b1;
                        end
                        REQ_SECOND:
                        begin
                            if (status.sec_full)
                                cmd.set_drop = 1'b1;
                            else if (status.first_zero)
                                cmd.sec_inc = 1'b1;
                            else
                            begin
                                cmd.col_start = 1'b1;
                                state_next    = ST_COL;
                            end
                        end
                        REQ_FINISH:
                        begin
                            cmd.fin_read = 1'b1;
                            state_next   = ST_FIN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_COL:
            begin
                cmd.col_step = 1'b1;
                if (status.last_cell)
                begin
                    cmd.sec_inc = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.fin_emit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A column walk always ends back in idle
    a_col_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COL && status.last_cell) |=> state_reg == ST_IDLE)
        else $error("column walk did not return to idle");

    // Only one kind of datapath work per cycle, apart from the closing increment
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_pat, cmd.set_drop, cmd.col_start, cmd.col_step,
                  cmd.fin_read, cmd.fin_emit}))
        else $error("conflicting datapath commands");

    // A finish request always leads to the finish state
    a_fin_enter: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_read |=> state_reg == ST_FIN)
        else $error("finish request lost");
`endif

endmodule

/* rtl/core/ede_datapath.sv */
`timescale 1ns / 1ps

module ede_datapath #(
    parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ede_pkg::SYM_W-1:0]  in_symbol,
    input  ede_pkg::ctrl_cmd_t         cmd,
    output ede_pkg::dp_status_t        status,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ede_pkg::DIST_W-1:0] out_distance,
    output logic                       out_dropped
);
    import ede_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int XW = (LW > DIST_W) ? LW : DIST_W;

    // Storage: first string, and cost column entries 1..first_len at index i-1
    logic [SYM_W-1:0] pat_mem [MAX_LEN];
    logic [LW-1:0]    col_mem [MAX_LEN];

    logic [LW-1:0]    first_len_reg;
    logic [LW-1:0]    sec_len_reg;
    logic             drop_reg;
    logic [LW-1:0]    idx_reg;
    logic [LW-1:0]    diag_reg;
    logic [LW-1:0]    up_reg;
    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] pat_q_reg;
    logic [LW-1:0]    col_q_reg;
    logic             out_valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic             out_drop_reg;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [LW-1:0]    left;
    logic [LW-1:0]    min_lu;
    logic [LW-1:0]    min_all;
    logic [LW-1:0]    cell_val;
    logic [LW-1:0]    dist_sel;
    logic [XW-1:0]    dist_ext;
    logic [LW-1:0]    fin_addr;

    // Status toward the controller
    assign status.first_zero = (first_len_reg == '0);
    assign status.first_full = (first_len_reg == LW'(MAX_LEN));
    assign status.sec_zero   = (sec_len_reg == '0);
    assign status.sec_full   = (sec_len_reg == LW'(MAX_LEN));
    assign status.last_cell  = (idx_reg == first_len_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    // Read address: first cell on start, next cell while walking, last on finish
    assign fin_addr = first_len_reg - LW'(1);
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.col_start)
        begin
            rd_en = 1'b1;
        end
        else if (cmd.col_step && !status.last_cell)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_reg[AW-1:0];
        end
        else if (cmd.fin_read && !status.first_zero)
        begin
            rd_en   = 1'b1;
            rd_addr = fin_addr[AW-1:0];
        end
    end

    // Cell update: old column is i on the first second-string symbol
    assign left     = status.sec_zero ? idx_reg : col_q_reg;
    assign min_lu   = (left < up_reg) ? left : up_reg;
    assign min_all  = (min_lu < diag_reg) ? min_lu : diag_reg;
    assign cell_val = (pat_q_reg == sym_reg) ? diag_reg : min_all + LW'(1);
    assign wr_addr  = AW'(idx_reg - LW'(1));

    // Pattern memory
    always_ff @(posedge clk)
    begin
        if (cmd.load_pat)
            pat_mem[first_len_reg[AW-1:0]] <= in_symbol;
        if (rd_en)
            pat_q_reg <= pat_mem[rd_addr];
    end

    // Cost column memory
    always_ff @(posedge clk)
    begin
        if (cmd.col_step)
            col_mem[wr_addr] <= cell_val;
        if (rd_en)
            col_q_reg <= col_mem[rd_addr];
    end

    // Walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.col_start)
        begin
            sym_reg  <= in_symbol;
            idx_reg  <= LW'(1);
            diag_reg <= sec_len_reg;
            up_reg   <= sec_len_reg + LW'(1);
        end
        else if (cmd.col_step)
        begin
            idx_reg  <= idx_reg + LW'(1);
            diag_reg <= left;
            up_reg   <= cell_val;
        end
    end

    // Lengths and drop flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg <= '0;
            sec_len_reg   <= '0;
            drop_reg      <= 1'b0;
        end
        else if (cmd.fin_emit)
        begin
            first_len_reg <= '0;
            sec_len_reg   <= '0;
            drop_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.load_pat)
                first_len_reg <= first_len_reg + LW'(1);
            if (cmd.sec_inc)
                sec_len_reg <= sec_len_reg + LW'(1);
            if (cmd.set_drop)
                drop_reg <= 1'b1;
        end
    end

    // Result selection
    always_comb
    begin
        if (status.sec_zero)
            dist_sel = first_len_reg;
        else if (status.first_zero)
            dist_sel = sec_len_reg;
        else
            dist_sel = col_q_reg;
    end
    assign dist_ext = XW'(dist_sel);

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_emit)
        begin
            dist_reg     <= dist_ext[DIST_W-1:0];
            out_drop_reg <= drop_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_distance = dist_reg;
    assign out_dropped  = out_drop_reg;

`ifndef SYNTHESIS
    // Column walk only runs over stored first-string cells
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.col_step |-> (idx_reg != '0 && idx_reg <= first_len_reg))
        else $error("cell index out of range");

    // The output register is never overwritten while a result waits
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_emit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");

    // A finish starts a clean pair
    a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_emit |=> (first_len_reg == '0 && sec_len_reg == '0 && !drop_reg))
        else $error("pair state not cleared");

    // Lengths stay within the store
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= LW'(MAX_LEN)) && (sec_len_reg <= LW'(MAX_LEN)))
        else $error("length beyond store size");
`endif

endmodule

/* rtl/core/edit_distance_engine.sv */
`timescale 1ns / 1ps

// Levenshtein edit distance engine.
// Input stream: tuser carries the request kind (0 first-string symbol,
// 1 second-string symbol, 2 finish), tdata the symbol byte.
// Output stream: one result per finish request; tdata holds the distance,
// tuser the dropped-symbol flag for that pair.
// Sequencing: a first-string symbol, a dropped symbol, an unused kind or a
// second-string symbol against an empty first string is handled in idle.
// A second-string symbol starts a walk of the cost column, one cell per
// cycle through a column memory with one write port and one registered
// read port. A finish reads the last cell from memory, then waits until
// the output register is free and loads it.
// The output register lets new symbols be taken while a result waits;
// a stalled receiver holds back the next finish and every request after
// it, since no input is taken while a finish waits.
// Reset clears lengths, drop flag, controller and output valid; the
// symbol and column memories are not cleared and need no clearing pass.

module edit_distance_engine #(
    parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  logic [1:0] s_axis_tuser,   // [1:0] req_type
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] distance, [7] zero
    output logic       m_axis_tuser    // [0] input_dropped
);
    import ede_pkg::*;

    ctrl_cmd_t         cmd;
    dp_status_t        status;
    logic [DIST_W-1:0] distance;

    // Sequencer
    ede_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_req   (s_axis_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // Storage, cell arithmetic and output register
    ede_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_symbol    (s_axis_tdata),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_distance (distance),
        .out_dropped  (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, distance};

endmodule
